// ===== rtl/lrc_line_parser_macros.svh =====
// Assertion macros shared by the lyrics line parser RTL.
// Each expects clk and rst in the scope where it is used.
`ifndef LRC_LINE_PARSER_MACROS_SVH
`define LRC_LINE_PARSER_MACROS_SVH

// Same-cycle implication check.
`define LRC_ASSERT_NOW(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("lrc_line_parser: same-cycle check failed");

// Next-cycle implication check.
`define LRC_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("lrc_line_parser: next-cycle check failed");

`endif

// ===== rtl/lrc_lp_pkg.sv =====
// Package for the lyrics line parser: field widths, line kinds, byte codes,
// time scale constants and the line snapshot passed from scan to classify.
package lrc_lp_pkg;

  localparam int MAX_LINE_DEF = 1024;
  localparam int TEXT_OFF_W   = 11;
  localparam int TIME_W       = 23;
  localparam int KIND_W       = 3;
  localparam int VAL_W        = 7;

  localparam logic [KIND_W-1:0] KIND_BLANK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TIMED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TITLE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ARTIST = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OTHER  = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_LO_I  = 8'h69;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_R  = 8'h72;

  localparam int MS_PER_MIN   = 60000;
  localparam int MS_PER_SEC   = 1000;
  localparam int MS_PER_CENTI = 10;
  localparam logic [TIME_W-1:0] MAX_TIME_MS = 23'd6039990;

  typedef struct packed {
    logic                  started;
    logic                  timed;
    logic [VAL_W-1:0]      minutes;
    logic [VAL_W-1:0]      seconds;
    logic [VAL_W-1:0]      centis;
    logic                  text_seen;
    logic [TEXT_OFF_W-1:0] text_start;
    logic                  tag_ok;
    logic                  title_ok;
    logic                  artist_ok;
  } snap_t;

endpackage

// ===== rtl/lrc_lp_scan.sv =====
// Per-line running state of the lyrics line parser: timestamp sequencer,
// tag matcher and positions. Depends on lrc_lp_pkg and the macro header.
`include "lrc_line_parser_macros.svh"
module lrc_lp_scan #(
  parameter int MAX_LINE = lrc_lp_pkg::MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_content,
  output logic              line_done,
  output lrc_lp_pkg::snap_t snap
);
  import lrc_lp_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

  typedef enum logic [10:0] {
    PH_OPEN   = 11'b000_0000_0001,
    PH_MIN    = 11'b000_0000_0010,
    PH_MIN2   = 11'b000_0000_0100,
    PH_SEC1   = 11'b000_0000_1000,
    PH_SEC2   = 11'b000_0001_0000,
    PH_DOT    = 11'b000_0010_0000,
    PH_CEN1   = 11'b000_0100_0000,
    PH_CEN2   = 11'b000_1000_0000,
    PH_CLOSE  = 11'b001_0000_0000,
    PH_TEXT   = 11'b010_0000_0000,
    PH_FAIL   = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0] raw_pos;
    logic [2:0]       trim_pos;
    logic             started;
    phase_t           phase;
    logic             min_two;
    logic [VAL_W-1:0] min_val;
    logic [VAL_W-1:0] sec_val;
    logic [VAL_W-1:0] cen_val;
    logic             text_seen;
    logic [POS_W-1:0] text_start;
    logic             prefix_ok;
    logic             title_ok;
    logic             artist_ok;
    logic [1:0]       close_cnt;
    logic             last_close;
  } scan_st_t;

  localparam scan_st_t ST_CLEAR = '{
    raw_pos: '0, trim_pos: 3'd0, started: 1'b0, phase: PH_OPEN, min_two: 1'b0,
    min_val: '0, sec_val: '0, cen_val: '0, text_seen: 1'b0, text_start: '0,
    prefix_ok: 1'b1, title_ok: 1'b1, artist_ok: 1'b1, close_cnt: 2'd0,
    last_close: 1'b0
  };

  scan_st_t st;
  scan_st_t st_next;
  scan_st_t view;

  logic             is_lf;
  logic             blank;
  logic             dig;
  logic [VAL_W-1:0] dval;
  logic [VAL_W-1:0] dval10;
  logic [7:0]       lc;

  assign is_lf    = (data_byte == CH_LF);
  assign line_done = is_lf || end_of_content;
  assign blank    = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                    (data_byte == CH_CR) || is_lf;
  assign dig      = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign dval     = dig ? {3'b000, data_byte[3:0]} : '0;
  assign dval10   = (dval << 3) + (dval << 1);
  assign lc       = ((data_byte >= CH_UP_A) && (data_byte <= CH_UP_Z)) ?
                    (data_byte | 8'h20) : data_byte;

  always_comb begin
    st_next = st;
    if (st.raw_pos != POS_MAX) begin
      st_next.raw_pos = st.raw_pos + 1'b1;
    end
    if (st.started || !blank) begin
      st_next.started = 1'b1;
      if (st.trim_pos != 3'd4) begin
        st_next.trim_pos = st.trim_pos + 3'd1;
      end
      unique case (st.phase)
        PH_OPEN: st_next.phase = (data_byte == CH_OPEN) ? PH_MIN : PH_FAIL;
        PH_MIN: begin
          if (dig) begin
            st_next.min_val = dval;
            st_next.phase   = PH_MIN2;
          end else begin
            st_next.phase = PH_FAIL;
          end
        end
        PH_MIN2: begin
          if (dig && !st.min_two) begin
            st_next.min_val = ((st.min_val << 3) + (st.min_val << 1)) + dval;
            st_next.min_two = 1'b1;
          end else if (data_byte == CH_COLON) begin
            st_next.phase = PH_SEC1;
          end else begin
            st_next.phase = PH_FAIL;
          end
        end
        PH_SEC1: begin
          st_next.sec_val = dval10;
          st_next.phase   = dig ? PH_SEC2 : PH_FAIL;
        end
        PH_SEC2: begin
          st_next.sec_val = st.sec_val + dval;
          st_next.phase   = dig ? PH_DOT : PH_FAIL;
        end
        PH_DOT: st_next.phase = (data_byte == CH_DOT) ? PH_CEN1 : PH_FAIL;
        PH_CEN1: begin
          st_next.cen_val = dval10;
          st_next.phase   = dig ? PH_CEN2 : PH_FAIL;
        end
        PH_CEN2: begin
          st_next.cen_val = st.cen_val + dval;
          st_next.phase   = dig ? PH_CLOSE : PH_FAIL;
        end
        PH_CLOSE: st_next.phase = (data_byte == CH_CLOSE) ? PH_TEXT : PH_FAIL;
        PH_TEXT: begin
          if (!blank && !st.text_seen) begin
            st_next.text_seen  = 1'b1;
            st_next.text_start = st.raw_pos;
          end
        end
        PH_FAIL: st_next.phase = PH_FAIL;
        default: st_next.phase = PH_FAIL;
      endcase
      case (st.trim_pos)
        3'd0: begin
          if (data_byte != CH_OPEN) st_next.prefix_ok = 1'b0;
        end
        3'd1: begin
          if (lc != CH_LO_T) st_next.title_ok = 1'b0;
          if (lc != CH_LO_A) st_next.artist_ok = 1'b0;
        end
        3'd2: begin
          if (lc != CH_LO_I) st_next.title_ok = 1'b0;
          if (lc != CH_LO_R) st_next.artist_ok = 1'b0;
        end
        3'd3: begin
          if (data_byte != CH_COLON) st_next.prefix_ok = 1'b0;
        end
        default: begin
          if ((data_byte == CH_CLOSE) && (st.close_cnt != 2'd3)) begin
            st_next.close_cnt = st.close_cnt + 2'd1;
          end
        end
      endcase
      if (!blank) st_next.last_close = (data_byte == CH_CLOSE);
    end
  end

  // an LF closes the line before it is scanned
  assign view = is_lf ? st : st_next;

  always_comb begin
    snap.started    = view.started;
    snap.timed      = (view.phase == PH_TEXT);
    snap.minutes    = view.min_val;
    snap.seconds    = view.sec_val;
    snap.centis     = view.cen_val;
    snap.text_seen  = view.text_seen;
    snap.text_start = TEXT_OFF_W'(view.text_start);
    snap.tag_ok     = view.prefix_ok && (view.close_cnt == 2'd1) && view.last_close;
    snap.title_ok   = view.title_ok;
    snap.artist_ok  = view.artist_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_CLEAR;
    end else if (step) begin
      st <= line_done ? ST_CLEAR : st_next;
    end
  end

  `LRC_ASSERT_NEXT(a_clear_after_line, step && line_done, st == ST_CLEAR)
  `LRC_ASSERT_NOW(a_timed_needs_content, st.phase == PH_TEXT, st.started)
  `LRC_ASSERT_NOW(a_close_needs_content, st.close_cnt != 2'd0, st.started)

endmodule

// ===== rtl/lrc_lp_classify.sv =====
// Line classification and millisecond time for the lyrics line parser.
// Depends on lrc_lp_pkg for the snapshot type and line kinds.
module lrc_lp_classify (
  input  lrc_lp_pkg::snap_t                   snap,
  output logic [lrc_lp_pkg::KIND_W-1:0]       line_kind,
  output logic [lrc_lp_pkg::TIME_W-1:0]       time_ms,
  output logic                                text_found,
  output logic [lrc_lp_pkg::TEXT_OFF_W-1:0]   text_offset
);
  import lrc_lp_pkg::*;

  logic [TIME_W-1:0] ms_sum;

  assign ms_sum = TIME_W'(snap.minutes) * TIME_W'(MS_PER_MIN) +
                  TIME_W'(snap.seconds) * TIME_W'(MS_PER_SEC) +
                  TIME_W'(snap.centis)  * TIME_W'(MS_PER_CENTI);

  always_comb begin
    line_kind   = KIND_OTHER;
    time_ms     = '0;
    text_found  = 1'b0;
    text_offset = '0;
    if (!snap.started) begin
      line_kind = KIND_BLANK;
    end else if (snap.timed) begin
      line_kind  = KIND_TIMED;
      time_ms    = ms_sum;
      text_found = snap.text_seen;
      if (snap.text_seen) text_offset = snap.text_start;
    end else if (snap.tag_ok) begin
      if (snap.title_ok) begin
        line_kind = KIND_TITLE;
      end else if (snap.artist_ok) begin
        line_kind = KIND_ARTIST;
      end
    end
  end

endmodule

// ===== rtl/lrc_line_parser.sv =====
// Lyrics line parser top level: input register, line scanner, classifier
// and result register. Depends on lrc_lp_pkg, lrc_lp_scan, lrc_lp_classify.
//
// Input channel: one content byte per request (data_byte, end_of_content),
// taken when in_valid is high and in_stall low. Output channel: one result
// per line (line_kind, time_ms, text_found, text_offset), taken when
// out_valid is high and out_stall low. A line ends at LF or at a byte with
// end_of_content set; other bytes give no result.
// Throughput: one byte per cycle while no result is stalled, set by the
// single-pass scan between the input register and the result register.
// A closing byte passes the input register, and its result the result
// register. Reset clears both valid flags and all line state; the next
// byte starts a new line. While a result is stalled, one more byte is
// held in the input register, then in_stall rises till the result is taken.
`include "lrc_line_parser_macros.svh"
module lrc_line_parser #(
  parameter int MAX_LINE = lrc_lp_pkg::MAX_LINE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                end_of_content,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lrc_lp_pkg::KIND_W-1:0]       line_kind,
  output logic [lrc_lp_pkg::TIME_W-1:0]       time_ms,
  output logic                                text_found,
  output logic [lrc_lp_pkg::TEXT_OFF_W-1:0]   text_offset
);
  import lrc_lp_pkg::*;

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  s1_eoc;
  logic                  advance;
  logic                  step;
  logic                  line_done;
  snap_t                 snap;
  logic [KIND_W-1:0]     kind_c;
  logic [TIME_W-1:0]     ms_c;
  logic                  found_c;
  logic [TEXT_OFF_W-1:0] off_c;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= data_byte;
      s1_eoc  <= end_of_content;
    end
  end

  lrc_lp_scan #(
    .MAX_LINE(MAX_LINE)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .data_byte      (s1_byte),
    .end_of_content (s1_eoc),
    .line_done      (line_done),
    .snap           (snap)
  );

  lrc_lp_classify u_classify (
    .snap        (snap),
    .line_kind   (kind_c),
    .time_ms     (ms_c),
    .text_found  (found_c),
    .text_offset (off_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && line_done;
    end
  end

  always_ff @(posedge clk) begin
    if (step && line_done) begin
      line_kind   <= kind_c;
      time_ms     <= ms_c;
      text_found  <= found_c;
      text_offset <= off_c;
    end
  end

  `LRC_ASSERT_NOW(a_untimed_zero, out_valid && (line_kind != KIND_TIMED), (time_ms == '0) && !text_found)
  `LRC_ASSERT_NOW(a_offset_needs_text, out_valid && !text_found, text_offset == '0)
  `LRC_ASSERT_NOW(a_time_range, out_valid, time_ms <= MAX_TIME_MS)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for lrc_line_parser: sends lyrics bytes over the
// valid/stall request channel and checks every line verdict against a line
// classifier kept in the bench. Depends on lrc_lp_pkg and the parser RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrc_lp_pkg::*;

  localparam int LINE_CAP     = MAX_LINE_DEF;
  localparam int WATCH_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 300;

  typedef enum int {
    STAMP_OPEN, STAMP_MIN_FIRST, STAMP_MIN_MORE, STAMP_SEC_TENS, STAMP_SEC_UNITS,
    STAMP_DOT, STAMP_CENTI_TENS, STAMP_CENTI_UNITS, STAMP_CLOSE, STAMP_TEXT, STAMP_FAIL
  } stamp_phase_t;

  typedef enum int {END_LF, END_EOC, END_LF_EOC} line_term_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [TIME_W-1:0]     ms;
    logic                  found;
    logic [TEXT_OFF_W-1:0] offset;
  } line_verdict_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = 8'h00;
  logic                  end_of_content = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KIND_W-1:0]     line_kind;
  logic [TIME_W-1:0]     time_ms;
  logic                  text_found;
  logic [TEXT_OFF_W-1:0] text_offset;

  // line classifier state
  int unsigned  raw_pos, trim_pos, min_digits, minutes, seconds, centis, lyric_pos;
  int unsigned  close_brackets;
  bit           started, lyric_seen, tag_shape_ok, title_ok, artist_ok, ends_on_close;
  stamp_phase_t phase;

  line_verdict_t pending_verdicts[$];
  logic [7:0]    line_buf[$];

  bit send_gaps_on = 1'b1;
  bit recv_stalls_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int rx_gap;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int lines_checked = 0;
  int bytes_sent = 0;
  int longest_in_stall = 0;
  int kind_count[5] = '{default: 0};

  lrc_line_parser i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_content (end_of_content),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .line_kind      (line_kind),
    .time_ms        (time_ms),
    .text_found     (text_found),
    .text_offset    (text_offset)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void buf_add(logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endfunction

  function automatic bit is_blank_char(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic void clear_line();
    raw_pos = 0; trim_pos = 0; started = 0; phase = STAMP_OPEN;
    min_digits = 0; minutes = 0; seconds = 0; centis = 0;
    lyric_seen = 0; lyric_pos = 0;
    tag_shape_ok = 1; title_ok = 1; artist_ok = 1;
    close_brackets = 0; ends_on_close = 0;
  endfunction

  function automatic void advance_stamp(logic [7:0] c, int unsigned raw_off);
    bit          dig;
    int unsigned d;
    dig = c >= CH_ZERO && c <= CH_NINE;
    d = dig ? int'(c - CH_ZERO) : 0;
    case (phase)
      STAMP_OPEN: phase = (c == CH_OPEN) ? STAMP_MIN_FIRST : STAMP_FAIL;
      STAMP_MIN_FIRST: begin
        if (dig) begin
          minutes = d; min_digits = 1; phase = STAMP_MIN_MORE;
        end else phase = STAMP_FAIL;
      end
      STAMP_MIN_MORE: begin
        if (dig && min_digits == 1) begin
          minutes = minutes * 10 + d; min_digits = 2;
        end else if (c == CH_COLON) phase = STAMP_SEC_TENS;
        else phase = STAMP_FAIL;
      end
      STAMP_SEC_TENS: begin
        if (dig) begin
          seconds = d * 10; phase = STAMP_SEC_UNITS;
        end else phase = STAMP_FAIL;
      end
      STAMP_SEC_UNITS: begin
        if (dig) begin
          seconds += d; phase = STAMP_DOT;
        end else phase = STAMP_FAIL;
      end
      STAMP_DOT: phase = (c == CH_DOT) ? STAMP_CENTI_TENS : STAMP_FAIL;
      STAMP_CENTI_TENS: begin
        if (dig) begin
          centis = d * 10; phase = STAMP_CENTI_UNITS;
        end else phase = STAMP_FAIL;
      end
      STAMP_CENTI_UNITS: begin
        if (dig) begin
          centis += d; phase = STAMP_CLOSE;
        end else phase = STAMP_FAIL;
      end
      STAMP_CLOSE: phase = (c == CH_CLOSE) ? STAMP_TEXT : STAMP_FAIL;
      STAMP_TEXT: begin
        if (!is_blank_char(c) && !lyric_seen) begin
          lyric_seen = 1; lyric_pos = raw_off;
        end
      end
      default: phase = STAMP_FAIL;
    endcase
  endfunction

  function automatic void advance_tag(logic [7:0] c, int unsigned t);
    logic [7:0] lc;
    lc = (c >= CH_UP_A && c <= CH_UP_Z) ? 8'(c - CH_UP_A + CH_LO_A) : c;
    if (t == 0) begin
      if (c != CH_OPEN) tag_shape_ok = 0;
    end else if (t == 1) begin
      if (lc != CH_LO_T) title_ok = 0;
      if (lc != CH_LO_A) artist_ok = 0;
    end else if (t == 2) begin
      if (lc != CH_LO_I) title_ok = 0;
      if (lc != CH_LO_R) artist_ok = 0;
    end else if (t == 3) begin
      if (c != CH_COLON) tag_shape_ok = 0;
    end else if (c == CH_CLOSE && close_brackets < 3) begin
      close_brackets++;
    end
    if (!is_blank_char(c)) ends_on_close = (c == CH_CLOSE);
  endfunction

  function automatic void take_char(logic [7:0] c);
    int unsigned raw_off;
    raw_off = (raw_pos < LINE_CAP) ? raw_pos : LINE_CAP;
    if (raw_pos < LINE_CAP) raw_pos++;
    if (!started) begin
      if (is_blank_char(c)) return;
      started = 1;
    end
    advance_stamp(c, raw_off);
    advance_tag(c, trim_pos);
    if (trim_pos < LINE_CAP) trim_pos++;
  endfunction

  function automatic line_verdict_t judge_line();
    line_verdict_t v;
    v = '0;
    v.kind = KIND_OTHER;
    if (!started) begin
      v.kind = KIND_BLANK;
    end else if (phase == STAMP_TEXT) begin
      v.kind = KIND_TIMED;
      v.ms = TIME_W'(minutes * MS_PER_MIN + seconds * MS_PER_SEC + centis * MS_PER_CENTI);
      if (lyric_seen) begin
        v.found = 1'b1;
        v.offset = TEXT_OFF_W'(lyric_pos);
      end
    end else if (tag_shape_ok && close_brackets == 1 && ends_on_close) begin
      if (title_ok) v.kind = KIND_TITLE;
      else if (artist_ok) v.kind = KIND_ARTIST;
    end
    return v;
  endfunction

  function automatic void close_line();
    pending_verdicts.insert(pending_verdicts.size(), judge_line());
    clear_line();
  endfunction

  function automatic void classify_byte(logic [7:0] c, logic eoc);
    if (c == CH_LF) begin
      close_line();
    end else begin
      take_char(c);
      if (eoc) close_line();
    end
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eoc);
    int gap;
    int run;
    gap = send_gaps_on ? pick_gap() : 0;
    run = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= c;
    end_of_content <= eoc;
    do begin
      @(posedge clk);
      if (in_stall !== 1'b0) run++;
    end while (in_stall !== 1'b0);
    if (run > longest_in_stall) longest_in_stall = run;
    classify_byte(c, eoc);
    bytes_sent++;
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) buf_add(s[i]);
  endfunction

  function automatic void put_blanks(int max_n);
    int r;
    repeat ($urandom_range(0, max_n)) begin
      r = $urandom_range(0, 2);
      buf_add(r == 0 ? CH_SPACE : (r == 1 ? CH_TAB : CH_CR));
    end
  endfunction

  function automatic void put_digits(int n);
    repeat (n) buf_add(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void put_words(int max_n);
    repeat ($urandom_range(0, max_n)) begin
      if ($urandom_range(0, 6) == 0) buf_add(CH_SPACE);
      else buf_add(8'($urandom_range(33, 126)));
    end
  endfunction

  function automatic void put_letter(logic [7:0] lower);
    buf_add($urandom_range(0, 1) ? lower : 8'(lower - CH_LO_A + CH_UP_A));
  endfunction

  function automatic void put_timed_line();
    int r;
    put_blanks(3);
    buf_add(CH_OPEN);
    r = $urandom_range(0, 9);
    put_digits(r == 0 ? 3 : (r < 5 ? 1 : 2));
    buf_add(CH_COLON);
    put_digits(2);
    buf_add(CH_DOT);
    put_digits(2);
    buf_add(CH_CLOSE);
    put_blanks(3);
    put_words(10);
    put_blanks(2);
  endfunction

  function automatic void put_tag_line();
    int r;
    put_blanks(2);
    buf_add(CH_OPEN);
    r = $urandom_range(0, 4);
    if (r < 2) begin
      put_letter(CH_LO_T); put_letter(CH_LO_I);
    end else if (r < 4) begin
      put_letter(CH_LO_A); put_letter(CH_LO_R);
    end else begin
      put_letter(8'(CH_LO_A + $urandom_range(0, 25)));
      put_letter(8'(CH_LO_A + $urandom_range(0, 25)));
    end
    buf_add($urandom_range(0, 9) != 0 ? CH_COLON : 8'($urandom_range(33, 126)));
    put_words(8);
    if ($urandom_range(0, 6) != 0) buf_add(CH_CLOSE);
    put_blanks(2);
    if ($urandom_range(0, 5) == 0) put_words(3);
  endfunction

  function automatic void build_random_line();
    int pick;
    int idx;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      put_timed_line();
    end else if (pick < 11) begin
      put_tag_line();
    end else if (pick < 12) begin
      put_blanks(4);
    end else if (pick < 14) begin
      repeat ($urandom_range(1, 12)) buf_add(8'($urandom_range(0, 255)));
    end else if (pick < 17) begin
      put_timed_line();
      idx = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: line_buf[idx] = 8'($urandom_range(0, 255));
        1: line_buf.delete(idx);
        default: line_buf.insert(idx, 8'($urandom_range(33, 126)));
      endcase
    end else begin
      put_blanks(2);
      put_words(15);
      put_blanks(2);
    end
  endfunction

  task automatic send_line(input line_term_t how);
    int n;
    n = line_buf.size();
    if (how == END_EOC && n == 0) how = END_LF_EOC;
    for (int i = 0; i < n; i++) send_byte(line_buf[i], how == END_EOC && i == n - 1);
    if (how != END_EOC) send_byte(CH_LF, how == END_LF_EOC);
    line_buf.delete();
  endtask

  task automatic send_text_line(input string s, input line_term_t how);
    put_text(s);
    send_line(how);
  endtask

  task automatic test_directed_lines();
    send_text_line("", END_LF);
    send_text_line(" \t\r ", END_LF);
    send_text_line("   ", END_EOC);
    send_text_line("", END_LF_EOC);
    send_text_line("[00:00.00]", END_EOC);
    send_text_line("[99:99.99] top", END_EOC);
    send_text_line("  [1:02.03]\t hello  ", END_LF);
    send_text_line("[05:75.50]   ", END_LF);
    send_text_line("[00:00.00]]x", END_LF);
    send_text_line("[123:00.00]x", END_LF);
    send_text_line("[1:2.03]x", END_LF);
    send_text_line("[ti:Song]", END_LF);
    send_text_line(" [TI:Song] \r", END_LF);
    send_text_line("[Ar:Band]", END_EOC);
    send_text_line("[aR:]", END_LF);
    send_text_line("[ar:a]b]", END_LF);
    send_text_line("[ti:a] x", END_LF);
    send_text_line("[ti]", END_LF);
    send_text_line("[al:Album]", END_LF);
    send_text_line("ti:x]", END_LF);
    send_text_line("plain words", END_LF_EOC);
    buf_add(8'h00);
    buf_add(8'hFF);
    send_line(END_EOC);
  endtask

  // lyric text starting past the position limit
  task automatic test_long_lines();
    put_text("[00:01.00]");
    repeat (LINE_CAP + 6) buf_add(CH_SPACE);
    put_text("x");
    send_line(END_EOC);
  endtask

  task automatic test_output_hold();
    send_gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_text_line("a", END_LF);
    repeat (10) send_text_line("[3:04.05]z", END_LF);
    send_gaps_on = 1'b1;
  endtask

  task automatic test_random_lines();
    int first;
    int lines;
    int r;
    first = bytes_sent;
    lines = 0;
    while (bytes_sent - first < RANDOM_BYTES) begin
      case ((lines / 3) % 4)
        0: begin send_gaps_on = 1'b1; recv_stalls_on = 1'b1; end
        1: begin send_gaps_on = 1'b1; recv_stalls_on = 1'b0; end
        2: begin send_gaps_on = 1'b0; recv_stalls_on = 1'b1; end
        default: begin send_gaps_on = 1'b0; recv_stalls_on = 1'b0; end
      endcase
      build_random_line();
      r = $urandom_range(0, 9);
      send_line(r < 6 ? END_LF : (r < 9 ? END_EOC : END_LF_EOC));
      lines++;
    end
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  // receiver side: random stalls plus a long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      rx_gap = recv_stalls_on ? pick_gap() : 0;
      out_stall <= (rx_gap > 0);
      stall_left = (rx_gap > 0) ? rx_gap - 1 : 0;
    end
  end

  always @(posedge clk) begin : result_check
    line_verdict_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, line_kind %0d", $time, line_kind);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        lines_checked++;
        if (line_kind <= KIND_OTHER) kind_count[line_kind]++;
        if (line_kind !== want.kind) begin
          $display("%0t: line_kind expected %0d got %0d", $time, want.kind, line_kind);
          mismatch_count++;
        end
        if (time_ms !== want.ms) begin
          $display("%0t: time_ms expected %0d got %0d", $time, want.ms, time_ms);
          mismatch_count++;
        end
        if (text_found !== want.found) begin
          $display("%0t: text_found expected %0d got %0d", $time, want.found, text_found);
          mismatch_count++;
        end
        if (text_offset !== want.offset) begin
          $display("%0t: text_offset expected %0d got %0d", $time, want.offset,
                   text_offset);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles, %0d results pending", $time,
               quiet_cycles, pending_verdicts.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_line();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_lines();
    test_long_lines();
    test_output_hold();
    test_random_lines();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Lines %0d: blank %0d, timed %0d, title %0d, artist %0d, other %0d",
             lines_checked, kind_count[0], kind_count[1], kind_count[2],
             kind_count[3], kind_count[4]);
    $display("Sent %0d bytes incl. a long line, input stalled up to %0d cycles",
             bytes_sent, longest_in_stall);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
